// File: rtl/core/pncm_pkg.sv
// shared types, codes and helper functions of the palette nearest color match block
// no dependencies; imported by the top level and its checker

package pncm_pkg;

  // input item kinds, carried in tuser
  localparam logic [2:0] KIND_PAL_WR  = 3'd0;
  localparam logic [2:0] KIND_CUBE_WR = 3'd1;
  localparam logic [2:0] KIND_GRAY_WR = 3'd2;
  localparam logic [2:0] KIND_QUERY   = 3'd3;
  localparam logic [2:0] KIND_PAL_RD  = 3'd4;

  // configuration register indexes
  localparam logic CFG_FIXED_MAP = 1'b0;
  localparam logic CFG_ACTIVE    = 1'b1;

  localparam int KIND_W   = 3;
  localparam int IDX8_W   = 8;
  localparam int LEVEL_W  = 10;
  localparam int PEN_W    = 8;
  localparam int RGB_W    = 24;
  localparam int ACT_W    = 9;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 32;
  localparam int ERR_W    = 10;
  localparam int CUBE_SIZE = 216;
  localparam int CUBE_AW   = 8;
  localparam int GRAY_SIZE = 32;
  localparam int GRAY_AW   = 5;

  // reciprocal of 125 scaled by 2^22, exact for numerators below 2^15
  localparam logic [15:0] RECIP_125 = 16'd33555;
  localparam int          RECIP_SH  = 22;
  // reciprocal of 3 scaled by 2^9, exact for numerators below 2^9
  localparam logic [7:0]  RECIP_3   = 8'd171;
  localparam int          RECIP3_SH = 9;

  localparam logic [7:0] GRAY_PRESET [GRAY_SIZE] = '{
    8'd1,   8'd244, 8'd243, 8'd255, 8'd245, 8'd236, 8'd58,  8'd246,
    8'd242, 8'd254, 8'd247, 8'd249, 8'd101, 8'd241, 8'd235, 8'd240,
    8'd239, 8'd248, 8'd238, 8'd144, 8'd234, 8'd237, 8'd253, 8'd252,
    8'd233, 8'd187, 8'd232, 8'd231, 8'd251, 8'd250, 8'd230, 8'd0
  };

  // max minus min of three channel bytes
  function automatic logic [7:0] sat_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    return hi - lo;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // (c*5+127)/255, one compare per level
  function automatic logic [2:0] quant6(input logic [7:0] c);
    logic [10:0] v;
    logic [2:0]  q;
    v = 11'(c) * 11'd5 + 11'd127;
    q = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (v >= 11'(255 * k)) q = 3'(k);
    end
    return q;
  endfunction

  // preset cube pens: pen 1, then pens 16 upward, last entry pen 0
  function automatic logic [7:0] cube_preset(input logic [CUBE_AW-1:0] i);
    logic [7:0] p;
    if (i == '0) p = 8'd1;
    else if (i == CUBE_AW'(CUBE_SIZE - 1)) p = 8'd0;
    else p = i + 8'd15;
    return p;
  endfunction

endpackage

// File: rtl/core/pncm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module pncm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/palette_nearest_color_match.sv
// palette nearest color match: one transaction at a time. A palette write passes each
// channel in turn through the shared scaling multiplier, then writes the store.
// A query in search mode walks the palette ram one entry per cycle from entry 0 up to
// the last active entry, ending early at an exact match; the single read port of the
// palette ram sets that pace. A fixed-map query passes through an index state and a
// table read state, a palette read through a read wait state; cube and gray table
// writes complete at acceptance. The block is not ready while an item is in work; a
// finished result waits in the output register, and the block accepts the next item
// meanwhile. A second result that finishes while the first one still waits holds the
// block in its result state until the output register frees up. Palette entries read
// before they were written return arbitrary data. Ties in the error sum go to the
// highest index. Depends on pncm_pkg and pncm_ram.

module palette_nearest_color_match
  import pncm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // entry_index[7:0], red_level[17:8], green_level[27:18], blue_level[37:28],
  // table_pen[45:38], query_rgb[69:46], zero fill[71:70]
  input  logic [IN_W-1:0]   in_tdata,
  // kind[2:0]
  input  logic [KIND_W-1:0] in_tuser,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // best_pen[7:0], entry_rgb[31:8]
  output logic [OUT_W-1:0]  out_tdata,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ACT_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(PALETTE_DEPTH - 1);
  localparam logic [ACT_W-1:0] DEPTH_A  = ACT_W'(PALETTE_DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SCALE   = 9'b000000010,
    ST_PWRITE  = 9'b000000100,
    ST_QPREP   = 9'b000001000,
    ST_SCAN    = 9'b000010000,
    ST_QFIX    = 9'b000100000,
    ST_QFIX_RD = 9'b001000000,
    ST_RDWAIT  = 9'b010000000,
    ST_RESULT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // input field split
  logic [KIND_W-1:0]  in_kind;
  logic [IDX8_W-1:0]  in_idx;
  logic [LEVEL_W-1:0] in_lvl [3];
  logic [PEN_W-1:0]   in_pen;
  logic [RGB_W-1:0]   in_rgb;
  logic               in_acc;

  assign in_kind   = in_tuser;
  assign in_idx    = in_tdata[7:0];
  assign in_lvl[0] = in_tdata[17:8];
  assign in_lvl[1] = in_tdata[27:18];
  assign in_lvl[2] = in_tdata[37:28];
  assign in_pen    = in_tdata[45:38];
  assign in_rgb    = in_tdata[69:46];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // item registers
  logic [IDX8_W-1:0]  idx_r;
  logic [LEVEL_W-1:0] lvl_r [3];
  logic [RGB_W-1:0]   qrgb_r;
  logic [1:0]         ch_r;
  logic [7:0]         scaled_r [3];
  logic [7:0]         qsat_r;
  logic [IDX_W-1:0]   cmp_r;
  logic [IDX_W-1:0]   last_r;
  logic [IDX_W-1:0]   best_r;
  logic [ERR_W-1:0]   low_sum_r;
  logic [CUBE_AW-1:0] cidx_r;
  logic [GRAY_AW-1:0] gidx_r;
  logic               is_gray_r;
  logic [PEN_W-1:0]   res_pen_r;
  logic [RGB_W-1:0]   res_rgb_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  // configuration
  logic               fixed_map_r;
  logic [ACT_W-1:0]   active_r;

  // tables
  logic               cube_vld_r [CUBE_SIZE];
  logic [7:0]         gray_r [GRAY_SIZE];

  // palette index in range of the store
  logic idx_ok_in;
  assign idx_ok_in = {1'b0, in_idx} < DEPTH_A;

  // ---------------------------------------------------------------
  // shared scaling unit: level*255+500, then /1000 as /8 and /125
  // ---------------------------------------------------------------
  logic [LEVEL_W-1:0] sc_lvl;
  logic [17:0]        sc_num;
  logic [30:0]        sc_prod;
  logic [8:0]         sc_quo;
  logic [7:0]         sc_byte;

  assign sc_lvl  = lvl_r[ch_r];
  assign sc_num  = (18'(sc_lvl) << 8) - 18'(sc_lvl) + 18'd500;
  assign sc_prod = 31'(sc_num[17:3]) * 31'(RECIP_125);
  assign sc_quo  = sc_prod[RECIP_SH +: 9];
  // levels above 1000 saturate
  assign sc_byte = (sc_quo > 9'd255) ? 8'hFF : sc_quo[7:0];

  // ---------------------------------------------------------------
  // palette store
  // ---------------------------------------------------------------
  logic             pal_we;
  logic [IDX_W-1:0] pal_raddr;
  logic [31:0]      pal_wdata;
  logic [31:0]      pal_rdata;

  assign pal_we    = (state_r == ST_PWRITE);
  assign pal_wdata = {sat_of(scaled_r[0], scaled_r[1], scaled_r[2]),
                      scaled_r[0], scaled_r[1], scaled_r[2]};

  // scan reads one entry ahead of the compare; an idle cycle reads the addressed entry
  always_comb begin
    pal_raddr = in_idx[IDX_W-1:0];
    if (state_r == ST_SCAN) pal_raddr = cmp_r + IDX_W'(1);
    else if (state_r == ST_QPREP) pal_raddr = '0;
  end

  pncm_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (idx_r[IDX_W-1:0]),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // ---------------------------------------------------------------
  // search compare: exact key and error sum of the entry just read
  // ---------------------------------------------------------------
  logic [31:0]      key;
  logic             hit;
  logic [ERR_W-1:0] err;
  logic             better;
  logic             at_last;

  assign key     = {qsat_r, qrgb_r};
  assign hit     = (pal_rdata == key);
  assign err     = ERR_W'(abs_diff(qrgb_r[23:16], pal_rdata[23:16]))
                 + ERR_W'(abs_diff(qrgb_r[15:8], pal_rdata[15:8]))
                 + ERR_W'(abs_diff(qrgb_r[7:0], pal_rdata[7:0]))
                 + ERR_W'(abs_diff(qsat_r, pal_rdata[31:24]));
  // equal sums move the choice to the later entry
  assign better  = (err <= low_sum_r);
  assign at_last = (cmp_r == last_r);

  // last entry searched, from the active count
  logic [IDX_W-1:0] last_calc;
  always_comb begin
    if (active_r == '0) last_calc = '0;
    else if (active_r > DEPTH_A) last_calc = LAST_MAX;
    else last_calc = IDX_W'(active_r - ACT_W'(1));
  end

  // ---------------------------------------------------------------
  // fixed map: quantized cube index and gray index
  // ---------------------------------------------------------------
  logic [2:0]         q_r, q_g, q_b;
  logic [CUBE_AW-1:0] cidx_calc;
  logic [9:0]         gsum;
  logic [15:0]        gprod;
  logic [PEN_W-1:0]   cube_rdata;

  assign q_r       = quant6(qrgb_r[23:16]);
  assign q_g       = quant6(qrgb_r[15:8]);
  assign q_b       = quant6(qrgb_r[7:0]);
  assign cidx_calc = (CUBE_AW'(q_r) * CUBE_AW'(6) + CUBE_AW'(q_g)) * CUBE_AW'(6)
                   + CUBE_AW'(q_b);
  // (r+g+b)/24 as (sum/8)/3
  assign gsum      = 10'(qrgb_r[23:16]) + 10'(qrgb_r[15:8]) + 10'(qrgb_r[7:0]);
  assign gprod     = 16'(gsum[9:3]) * 16'(RECIP_3);

  pncm_ram #(
    .WIDTH (PEN_W),
    .DEPTH (CUBE_SIZE)
  ) u_cube_ram (
    .clk   (clk),
    .we    (in_acc && (in_kind == KIND_CUBE_WR) && (in_idx < IDX8_W'(CUBE_SIZE))),
    .waddr (in_idx),
    .wdata (in_pen),
    .raddr (cidx_calc),
    .rdata (cube_rdata)
  );

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  logic out_load;
  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_PAL_WR: state_nxt = idx_ok_in ? ST_SCALE : ST_IDLE;
            KIND_QUERY:  state_nxt = fixed_map_r ? ST_QFIX : ST_QPREP;
            KIND_PAL_RD: state_nxt = idx_ok_in ? ST_RDWAIT : ST_RESULT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCALE:   if (ch_r == 2'd2) state_nxt = ST_PWRITE;
      ST_PWRITE:  state_nxt = ST_IDLE;
      ST_QPREP:   state_nxt = ST_SCAN;
      ST_SCAN:    if (hit || at_last) state_nxt = ST_RESULT;
      ST_QFIX:    state_nxt = ST_QFIX_RD;
      ST_QFIX_RD: state_nxt = ST_RESULT;
      ST_RDWAIT:  state_nxt = ST_RESULT;
      ST_RESULT:  if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        idx_r     <= in_idx;
        lvl_r     <= in_lvl;
        qrgb_r    <= in_rgb;
        ch_r      <= 2'd0;
        res_pen_r <= '0;
        res_rgb_r <= '0;
      end
      ST_SCALE: begin
        scaled_r[ch_r] <= sc_byte;
        ch_r           <= ch_r + 2'd1;
      end
      ST_QPREP: begin
        qsat_r    <= sat_of(qrgb_r[23:16], qrgb_r[15:8], qrgb_r[7:0]);
        cmp_r     <= '0;
        last_r    <= last_calc;
        best_r    <= '0;
        low_sum_r <= '1;
      end
      ST_SCAN: begin
        if (better) begin
          low_sum_r <= err;
          best_r    <= cmp_r;
        end
        cmp_r <= cmp_r + IDX_W'(1);
        if (hit || (at_last && better)) begin
          res_pen_r <= PEN_W'(cmp_r);
        end else begin
          res_pen_r <= PEN_W'(best_r);
        end
      end
      ST_QFIX: begin
        cidx_r    <= cidx_calc;
        gidx_r    <= gprod[RECIP3_SH +: GRAY_AW];
        is_gray_r <= (q_r == q_g) && (q_g == q_b);
      end
      ST_QFIX_RD: begin
        if (is_gray_r) res_pen_r <= gray_r[gidx_r];
        else if (cube_vld_r[cidx_r]) res_pen_r <= cube_rdata;
        else res_pen_r <= cube_preset(cidx_r);
      end
      ST_RDWAIT: begin
        res_rgb_r <= pal_rdata[RGB_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // cube valid bits and gray table; unwritten cube entries read as their preset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_vld_r <= '{default: 1'b0};
      gray_r     <= GRAY_PRESET;
    end else if (in_acc) begin
      if ((in_kind == KIND_CUBE_WR) && (in_idx < IDX8_W'(CUBE_SIZE))) begin
        cube_vld_r[in_idx] <= 1'b1;
      end
      if ((in_kind == KIND_GRAY_WR) && (in_idx < IDX8_W'(GRAY_SIZE))) begin
        gray_r[in_idx[GRAY_AW-1:0]] <= in_pen;
      end
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {res_rgb_r, res_pen_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_map_r <= 1'b0;
      active_r    <= DEPTH_A;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIXED_MAP: fixed_map_r <= cfg_data[0];
        CFG_ACTIVE:    active_r    <= cfg_data;
        default:       active_r    <= active_r;
      endcase
    end
  end

endmodule

// File: rtl/core/pncm_checker.sv
// port-level checker of palette_nearest_color_match, bound to the top level
// depends on pncm_pkg

module pncm_port_checker
  import pncm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [KIND_W-1:0] in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == KIND_QUERY) |=> !in_tready)
    else $error("ready right after a query transaction");

  // table writes and unknown kinds complete at once
  a_table_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_tuser == KIND_CUBE_WR) || (in_tuser == KIND_GRAY_WR) ||
               (in_tuser > KIND_PAL_RD)) |=> in_tready)
    else $error("not ready after a table write or unknown kind");

  // a palette write gives no result
  a_pal_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == KIND_PAL_WR) |=> !$rose(out_tvalid))
    else $error("result after a palette write");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

endmodule

bind palette_nearest_color_match pncm_port_checker u_pncm_port_checker (.*);
